// ===== rtl/core/deviate_weight_estimator_assert.svh =====
// assertion macros for the deviate weight estimator
`ifndef DEVIATE_WEIGHT_ESTIMATOR_ASSERT_SVH
`define DEVIATE_WEIGHT_ESTIMATOR_ASSERT_SVH
// implication checked at every clock edge outside reset
`define DWE_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: check failed");
// next-cycle implication
`define DWE_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: check failed");
`endif

// ===== rtl/core/dwe_pkg.sv =====
// package of the deviate weight estimator
package dwe_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned POS_W  = 6;
  localparam logic [DATA_W-1:0] SAT32 = '1;
  localparam logic [FRAC_W-1:0] FLOOR_FRACTION_RESET = 16'd3277;
  typedef logic [DATA_W-1:0] data_t;
endpackage

// ===== rtl/core/dwe_if.sv =====
// stream interfaces of the deviate weight estimator
interface dwe_in_if;
  logic               valid;
  logic               ready;
  dwe_pkg::data_t     deviate;
  dwe_pkg::data_t     prior_weight;
  logic               is_last;
  modport source (output valid, deviate, prior_weight, is_last, input ready);
  modport sink   (input valid, deviate, prior_weight, is_last, output ready);
endinterface

interface dwe_out_if;
  logic                        valid;
  logic                        ready;
  dwe_pkg::data_t              weight;
  logic [dwe_pkg::POS_W-1:0]   position;
  logic                        last_weight;
  modport source (output valid, weight, position, last_weight, input ready);
  modport sink   (input valid, weight, position, last_weight, output ready);
endinterface

// ===== rtl/core/deviate_weight_estimator.sv =====
// top level of the deviate weight estimator
// sequence: load the words, scan for the maximum, rank scan for the median, then per weight
// either one divider run or a direct pass of the prior weight, plus sink stalls
// throughput: one set at a time, input ready only while loading
// rank count runs one compare at a time, one divider run per divided weight
// reset: synchronous active low, clears control, floor_fraction to 3277
module deviate_weight_estimator #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [dwe_pkg::FRAC_W-1:0] cfg_wdata,
  dwe_in_if.sink               in_ch,
  dwe_out_if.source            out_ch
);
  import dwe_pkg::*;
  `include "deviate_weight_estimator_assert.svh"

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  // sequencer states
  localparam logic [2:0] S_LOAD = 3'd0, S_MAX = 3'd1, S_RANK = 3'd2, S_THR = 3'd3,
                         S_RD = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6, S_RD2 = 3'd7;

  data_t dev_mem [MAX_ITEMS];
  data_t pri_mem [MAX_ITEMS];

  logic [2:0]        state_r;
  logic [CW-1:0]     count_r;     // items in the set
  logic [IW-1:0]     i_r, j_r;    // scan indices
  logic [CW-1:0]     less_r, leq_r;
  logic              found_r;
  logic              launched_r;  // divider started for this weight
  data_t             max_r, thr_r, cand_r;
  data_t             rd_dev_r, rd_pri_r;   // registered memory read
  logic [FRAC_W-1:0] ff_r;
  data_t             w_r;
  logic              div_start;
  logic              div_done;
  data_t             div_q;
  data_t             eff;
  logic [CW-1:0]     half;
  logic [47:0]       prod;
  data_t             bound;

  assign eff  = (rd_pri_r == '0) ? '0 : rd_dev_r;
  assign half = count_r >> 1;
  assign prod = 48'(max_r) * 48'(ff_r);
  assign bound = prod[47:16];

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) ff_r <= FLOOR_FRACTION_RESET;
    else if (cfg_we) ff_r <= cfg_wdata;
  end

  // store writes, registered reads at scan index
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      dev_mem[count_r[IW-1:0]] <= in_ch.deviate;
      pri_mem[count_r[IW-1:0]] <= in_ch.prior_weight;
    end
    rd_dev_r <= dev_mem[(state_r == S_RANK) ? j_r : i_r];
    rd_pri_r <= pri_mem[(state_r == S_RANK) ? j_r : i_r];
  end

  assign in_ch.ready = (state_r == S_LOAD);
  // one start pulse per divided weight, once its entry has been read
  assign div_start = (state_r == S_DIV) && found_r && !launched_r
                     && (rd_pri_r != '0) && (max_r != '0);

  dwe_recip u_recip (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .v    ((rd_dev_r < thr_r) ? thr_r : rd_dev_r),
    .done (div_done),
    .q    (div_q)
  );

  // found_r: candidate latched in the rank scan, entry read in the weight stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      out_ch.valid <= 1'b0;
      found_r <= 1'b0;
      launched_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_ch.valid) begin
            count_r <= count_r + 1'b1;
            if (in_ch.is_last || (count_r == CW'(MAX_ITEMS - 1))) begin
              state_r <= S_RD;
              i_r <= '0;
              max_r <= '0;
            end
          end
        end
        S_RD: state_r <= S_MAX;   // read latency for i_r
        S_MAX: begin
          // rd holds entry i_r
          if (eff > max_r) max_r <= eff;
          if (CW'(i_r) == count_r - 1'b1) begin
            i_r <= '0; j_r <= '0; less_r <= '0; leq_r <= '0; found_r <= 1'b0;
            state_r <= S_RD2;
          end else begin
            i_r <= i_r + 1'b1; state_r <= S_RD;
          end
        end
        S_RD2: state_r <= S_RANK;   // read issued for candidate i_r
        S_RANK: begin
          // first visit: rd holds the candidate; read issued for j_r
          if (!found_r) begin
            cand_r <= eff;
            found_r <= 1'b1;
          end
          state_r <= S_THR;
        end
        S_THR: begin
          // rd holds entry j_r
          if (CW'(j_r) == count_r - 1'b1) begin
            if ((less_r + CW'(eff < cand_r)) <= half
                && half < (leq_r + CW'(eff <= cand_r))) begin
              thr_r <= (max_r == '0) ? '0 : ((cand_r < bound) ? bound : cand_r);
              i_r <= '0;
              found_r <= 1'b0;
              launched_r <= 1'b0;
              state_r <= S_DIV;
            end else begin
              i_r <= i_r + 1'b1;
              j_r <= '0; less_r <= '0; leq_r <= '0; found_r <= 1'b0;
              state_r <= S_RD2;
            end
          end else begin
            if (eff < cand_r) less_r <= less_r + 1'b1;
            if (eff <= cand_r) leq_r <= leq_r + 1'b1;
            j_r <= j_r + 1'b1;
            state_r <= S_RANK;
          end
        end
        S_DIV: begin
          if (!found_r) begin
            found_r <= 1'b1;           // wait for the registered read of i_r
          end else if (rd_pri_r == '0 || max_r == '0) begin
            w_r <= rd_pri_r; out_ch.valid <= 1'b1; state_r <= S_OUT;
          end else if (!launched_r) begin
            launched_r <= 1'b1;        // divider starts this cycle
          end else if (div_done) begin
            w_r <= div_q; out_ch.valid <= 1'b1; state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            found_r <= 1'b0;
            launched_r <= 1'b0;
            if (CW'(i_r) == count_r - 1'b1) begin
              state_r <= S_LOAD; count_r <= '0;
            end else begin
              i_r <= i_r + 1'b1; state_r <= S_DIV;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.weight = w_r;
  assign out_ch.position = POS_W'(i_r);
  assign out_ch.last_weight = (CW'(i_r) == count_r - 1'b1);

  `DWE_ASSERT_IMP(a_ready_load, clk, rst_n, in_ch.ready, state_r == S_LOAD)
  `DWE_ASSERT_IMP(a_valid_out, clk, rst_n, out_ch.valid, state_r == S_OUT)
  `DWE_ASSERT_NXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

// ===== rtl/core/dwe_recip.sv =====
// iterative restoring divider: floor(2^48 / v^2), saturated
module dwe_recip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  dwe_pkg::data_t v,
  output logic           done,
  output dwe_pkg::data_t q
);
  import dwe_pkg::*;
  // divide 2^48 by 64-bit square, one quotient bit per cycle over 49 bits
  logic [63:0] sq_r;
  logic [64:0] rem_r, rem_sh;
  logic [48:0] quo_r;
  logic [5:0]  cnt_r;
  logic        busy_r, sqz_r, done_r;
  logic [5:0]  st_r;

  assign rem_sh = {rem_r[63:0], (cnt_r == 6'd48)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd48;
        st_r   <= 6'd0;
        sq_r   <= 64'(v) * 64'(v);
        sqz_r  <= (v == '0);
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        if (st_r == 6'd0) begin
          st_r <= 6'd1;
        end else begin
          if (rem_sh >= {1'b0, sq_r}) begin
            rem_r <= rem_sh - {1'b0, sq_r};
            quo_r <= {quo_r[47:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[47:0], 1'b0};
          end
          if (cnt_r == 6'd0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign q = (sqz_r || (quo_r[48:32] != '0)) ? SAT32 : quo_r[31:0];
endmodule

// ===== test/tb_deviate_weight_estimator.sv =====
// self-checking testbench of the deviate weight estimator
`timescale 1ns / 100ps

module tb_deviate_weight_estimator;
  import dwe_pkg::*;

  localparam int unsigned SET_MAX    = 64;
  localparam int unsigned DRAIN_WAIT = 200;     // settle time after the last weight
  localparam int unsigned STALL_MAX  = 30000;   // cycles with no word moving

  typedef struct packed {
    data_t deviate;
    data_t prior;
    logic  is_last;
  } obs_t;

  typedef struct packed {
    data_t             weight;
    logic [POS_W-1:0]  position;
    logic              last_weight;
  } wgt_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [FRAC_W-1:0] cfg_wdata;

  dwe_in_if  in_if();
  dwe_out_if out_if();

  deviate_weight_estimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  obs_t        pending_obs[$];     // words waiting for the driver
  wgt_t        expected_wgt[$];    // weights predicted, not yet seen
  obs_t        open_set[$];        // observations of the set being loaded
  logic [FRAC_W-1:0] floor_frac_q; // predictor copy of the register
  int unsigned errors = 0;
  int unsigned obs_queued = 0, obs_taken = 0, wgt_seen = 0, sets_closed = 0;
  int unsigned idle_cycles = 0;
  bit          drv_burst = 0, snk_burst = 0;
  int unsigned drv_gap = 0, snk_stall = 0;

  // 1 / v^2 in Q16.16, saturating; zero saturates too
  function automatic data_t inv_square(data_t v);
    logic [63:0] sq;
    logic [63:0] q;
    sq = {32'b0, v} * {32'b0, v};
    if (sq == 64'd0) return SAT32;
    q = (64'd1 << 48) / sq;
    return (q > {32'b0, SAT32}) ? SAT32 : q[DATA_W-1:0];
  endfunction

  // weights of one closed set, appended to the expected queue
  task automatic predict_weights();
    data_t eff[$];
    data_t peak, med, bound, thr, w;
    logic [63:0] prod;
    int unsigned n, k, less, leq;
    bit found;
    n = open_set.size();
    peak = '0;
    for (int i = 0; i < n; i++) begin
      eff.push_back((open_set[i].prior == '0) ? data_t'(0) : open_set[i].deviate);
      if (eff[i] > peak) peak = eff[i];
    end
    thr = '0;
    if (peak != '0) begin
      // upper median: rank n/2 in ascending order, excluded items count as zero
      k = n / 2;
      med = '0;
      found = 0;
      for (int i = 0; i < n && !found; i++) begin
        less = 0;
        leq = 0;
        for (int j = 0; j < n; j++) begin
          if (eff[j] < eff[i]) less++;
          if (eff[j] <= eff[i]) leq++;
        end
        if (less <= k && k < leq) begin
          med = eff[i];
          found = 1;
        end
      end
      prod = {32'b0, peak} * {48'b0, floor_frac_q};
      bound = prod[47:16];
      thr = (med < bound) ? bound : med;
    end
    for (int i = 0; i < n; i++) begin
      w = open_set[i].prior;
      if (peak != '0 && w != '0)
        w = (open_set[i].deviate < thr) ? inv_square(thr) : inv_square(open_set[i].deviate);
      expected_wgt.push_back('{weight: w, position: POS_W'(i), last_weight: (i == n - 1)});
    end
    open_set.delete();
    sets_closed++;
  endtask

  // driver: one word at a time, random gap drawn per word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold the word until taken
    end else if (drv_gap > 0) begin
      in_if.valid <= 1'b0;
      drv_gap <= drv_gap - 1;
    end else if (pending_obs.size() > 0) begin
      obs_t o;
      o = pending_obs.pop_front();
      in_if.valid        <= 1'b1;
      in_if.deviate      <= o.deviate;
      in_if.prior_weight <= o.prior;
      in_if.is_last      <= o.is_last;
      if ($urandom_range(0, 19) == 0) drv_burst <= ~drv_burst;
      drv_gap <= drv_burst ? 0 : $urandom_range(0, 14);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // sink: random stall drawn per word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      int unsigned s;
      s = snk_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 19) == 0) snk_burst <= ~snk_burst;
      snk_stall    <= s;
      out_if.ready <= (s == 0);
    end else if (snk_stall > 0) begin
      out_if.ready <= 1'b0;
      snk_stall    <= snk_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted inputs, check accepted weights
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        obs_taken++;
        open_set.push_back('{deviate: in_if.deviate, prior: in_if.prior_weight,
                             is_last: in_if.is_last});
        // the word that fills the store ends the set even without the flag
        if (in_if.is_last || open_set.size() == SET_MAX) predict_weights();
      end
      if (out_if.valid && out_if.ready) begin
        wgt_seen++;
        if (expected_wgt.size() == 0) begin
          errors++;
          $display("%0t: unexpected weight %h pos %0d last %b", $time,
                   out_if.weight, out_if.position, out_if.last_weight);
        end else begin
          wgt_t e;
          e = expected_wgt.pop_front();
          if (e.weight !== out_if.weight) begin
            errors++;
            $display("%0t: weight exp %h got %h", $time, e.weight, out_if.weight);
          end
          if (e.position !== out_if.position) begin
            errors++;
            $display("%0t: position exp %0d got %0d", $time, e.position, out_if.position);
          end
          if (e.last_weight !== out_if.last_weight) begin
            errors++;
            $display("%0t: last_weight exp %b got %b", $time, e.last_weight,
                     out_if.last_weight);
          end
        end
      end
    end
  end

  // watchdog: counts cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("deviate_weight_estimator: mismatch");
      $finish;
    end
  end

  task automatic queue_obs(data_t dev, data_t pw, logic last);
    pending_obs.push_back('{deviate: dev, prior: pw, is_last: last});
    obs_queued++;
  endtask

  // random deviate: full range, small values, near-maximum values, zeros and repeats
  function automatic data_t rand_dev(data_t prev);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return prev;
      2:       return $urandom_range(0, 32'h0003_0000);
      3:       return SAT32 - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic data_t rand_prior();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SAT32;
      2:       return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // one set of n words with random content, flagged last unless it fills the store
  task automatic queue_rand_set(int unsigned n);
    data_t d;
    d = $urandom;
    for (int i = 0; i < n; i++) begin
      d = rand_dev(d);
      queue_obs(d, rand_prior(), (i == n - 1) && (n < SET_MAX));
    end
  endtask

  // block until every word is taken and every weight checked, then let it settle
  task automatic wait_idle();
    while (obs_taken != obs_queued || expected_wgt.size() != 0 || open_set.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_floor_fraction(logic [FRAC_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_frac_q = v;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    floor_frac_q       = FLOOR_FRACTION_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset value of the floor fraction
    queue_obs(32'h0002_0000, 32'h0001_0000, 1'b1);            // single word set
    queue_obs(SAT32, SAT32, 1'b0);                            // field extremes
    queue_obs(32'h0000_0001, SAT32, 1'b0);
    queue_obs(32'h0, 32'h0000_0001, 1'b1);
    queue_obs(32'h0, 32'h0001_0000, 1'b0);                    // zero maximum
    queue_obs(32'h0, 32'h0, 1'b0);
    queue_obs(32'h1234_5678, 32'h0, 1'b1);                    // excluded only
    queue_obs(32'h0001_0000, 32'h0001_0000, 1'b0);            // ties at the median
    queue_obs(32'h0001_0000, 32'h0002_0000, 1'b0);
    queue_obs(32'h0100_0000, 32'h0003_0000, 1'b0);
    queue_obs(32'h0000_0100, 32'h0004_0000, 1'b1);            // below the floor
    wait_idle();

    // zero floor: a zero deviate against a zero threshold saturates
    write_floor_fraction('0);
    queue_obs(32'h0, 32'h0001_0000, 1'b0);
    queue_obs(32'h0, 32'h0001_0000, 1'b0);
    queue_obs(32'h0005_0000, 32'h0001_0000, 1'b1);
    queue_rand_set(6);
    wait_idle();

    // full floor, plus one set that fills the store
    write_floor_fraction('1);
    queue_obs(32'h0008_0000, 32'h0001_0000, 1'b0);
    queue_obs(32'h0000_8000, 32'h0001_0000, 1'b1);
    queue_rand_set(SET_MAX);
    queue_rand_set(5);
    wait_idle();

    // random part over several floor settings
    while (obs_queued < 195) begin
      write_floor_fraction(($urandom_range(0, 3) == 0) ? FLOOR_FRACTION_RESET
                                                       : FRAC_W'($urandom));
      repeat ($urandom_range(2, 5))
        queue_rand_set(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10));
      wait_idle();
    end

    $display("%0d words in %0d sets loaded, %0d weights checked, %0d errors",
             obs_taken, sets_closed, wgt_seen, errors);
    $display("covered: extremes, exclusions, zero maximum, zero divisor, overflow, floors");
    if (errors == 0)
      $display("deviate_weight_estimator: match");
    else
      $display("deviate_weight_estimator: mismatch");
    $finish;
  end

endmodule
